[rtl/crr_pkg.sv]
package crr_pkg;

  localparam int PES_PER_CLUSTER = 16;
  localparam int PTR_W = 4;
  localparam int COUNT_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CLUSTER_W = 2;
  localparam int NUM_COUNT_REGS = 4;

  localparam int DEF_NUM_CLUSTERS = 4;
  localparam int DEF_MAX_PES = 16;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
  localparam logic [CFG_DATA_W-1:0] ENABLE_RESET = '1;

  localparam logic [CFG_IDX_W-1:0] REG_PE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PE_COUNT0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PE_COUNT1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PE_COUNT2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PE_COUNT3 = 3'd4;

  typedef struct packed {
    logic [CLUSTER_W-1:0]       cluster_index;
    logic [PES_PER_CLUSTER-1:0] mappable_mask;
  } crr_req_t;

  typedef struct packed {
    logic             found;
    logic [PTR_W-1:0] pe_index;
  } crr_rsp_t;

  typedef struct packed {
    logic             found;
    logic [PTR_W-1:0] pe_index;
    logic [PTR_W-1:0] ptr_next;
  } crr_search_t;

endpackage

[rtl/crr_ram.sv]
module crr_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/crr_search.sv]
module crr_search import crr_pkg::*; #(
  parameter int MAX_PES = DEF_MAX_PES
) (
  input  logic                       cluster_ok,
  input  logic [PTR_W-1:0]           ptr,
  input  logic [COUNT_W-1:0]         count,
  input  logic [PES_PER_CLUSTER-1:0] enable,
  input  logic [PES_PER_CLUSTER-1:0] mask,
  output crr_search_t                result
);

  logic [COUNT_W-1:0] n;
  logic [PTR_W-1:0]   start;
  logic [MAX_PES-1:0] elig;
  logic [MAX_PES-1:0] upper;
  logic [MAX_PES-1:0] pick;
  logic [PTR_W-1:0]   idx;
  logic [COUNT_W-1:0] idx_inc;

  always_comb begin
    n = (count > COUNT_W'(MAX_PES)) ? COUNT_W'(MAX_PES) : count;

    // The stored pointer may be stale after a count change, so it is
    // reduced modulo the count by testing every possible quotient.
    start = '0;
    for (int k = 0; k < PES_PER_CLUSTER; k++) begin
      if ((9'(ptr) >= 9'(k) * 9'(n)) && (9'(ptr) < (9'(k) + 9'd1) * 9'(n))) begin
        start = PTR_W'(9'(ptr) - 9'(k) * 9'(n));
      end
    end

    for (int i = 0; i < MAX_PES; i++) begin
      elig[i]  = cluster_ok && (COUNT_W'(i) < n) && enable[i] && mask[i];
      upper[i] = elig[i] && (PTR_W'(i) >= start);
    end

    pick = (|upper) ? upper : elig;
    idx = '0;
    for (int i = MAX_PES - 1; i >= 0; i--) begin
      if (pick[i]) begin
        idx = PTR_W'(i);
      end
    end

    idx_inc = COUNT_W'(idx) + COUNT_W'(1);
    result.found    = |elig;
    result.pe_index = (|elig) ? idx : '0;
    result.ptr_next = (idx_inc == n) ? '0 : PTR_W'(idx_inc);
  end

endmodule

[rtl/clustered_round_robin_pe_picker.sv]
// Channel   Direction  Word        Handshake
// req       in         crr_req_t   req_valid / req_stall
// rsp       out        crr_rsp_t   rsp_valid / rsp_stall
// cfg       in         3b index    cfg_we, 64-bit cfg_data
//
// Each word is handled in two steps: the cluster's pointer is read from the
// pointer memory, then the search runs and the pointer is written back.
// A new request is taken at the earliest in the cycle after the previous
// write-back, so a read never overlaps a write of the same pointer.
// Reset clears the pointer valid bits at once; an unwritten pointer reads as zero.
// A stalled response holds the search step until the output register frees.
module clustered_round_robin_pe_picker import crr_pkg::*; #(
  parameter int NUM_CLUSTERS = DEF_NUM_CLUSTERS,
  parameter int MAX_PES = DEF_MAX_PES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  crr_req_t              req_word,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output crr_rsp_t              rsp_word
);

  localparam int AW = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  state_t                  state;
  logic [CFG_DATA_W-1:0]   pe_enable_bits;
  logic [COUNT_W-1:0]      pe_count [NUM_COUNT_REGS];
  logic [NUM_CLUSTERS-1:0] ptr_valid;
  crr_req_t                held;
  logic [PTR_W-1:0]        ptr_rdata;
  logic [PTR_W-1:0]        ptr_cur;
  logic [AW-1:0]           held_addr;
  logic                    cluster_ok;
  logic                    accept;
  logic                    finish;
  crr_search_t             search;

  assign req_stall  = (state != ST_IDLE);
  assign accept     = req_valid && !req_stall;
  assign finish     = (state == ST_CALC) && (!rsp_valid || !rsp_stall);
  assign held_addr  = AW'(held.cluster_index);
  assign cluster_ok = ({1'b0, held.cluster_index} < (CLUSTER_W + 1)'(NUM_CLUSTERS));
  assign ptr_cur    = (cluster_ok && ptr_valid[held_addr]) ? ptr_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pe_enable_bits <= ENABLE_RESET;
      for (int i = 0; i < NUM_COUNT_REGS; i++) begin
        pe_count[i] <= COUNT_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PE_ENABLE: pe_enable_bits <= cfg_data;
        REG_PE_COUNT0: pe_count[0] <= cfg_data[COUNT_W-1:0];
        REG_PE_COUNT1: pe_count[1] <= cfg_data[COUNT_W-1:0];
        REG_PE_COUNT2: pe_count[2] <= cfg_data[COUNT_W-1:0];
        REG_PE_COUNT3: pe_count[3] <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  crr_ram #(
    .WIDTH(PTR_W),
    .DEPTH(NUM_CLUSTERS)
  ) u_ptr_ram (
    .clk  (clk),
    .we   (finish && search.found),
    .waddr(held_addr),
    .wdata(search.ptr_next),
    .re   (accept),
    .raddr(AW'(req_word.cluster_index)),
    .rdata(ptr_rdata)
  );

  crr_search #(
    .MAX_PES(MAX_PES)
  ) u_search (
    .cluster_ok(cluster_ok),
    .ptr       (ptr_cur),
    .count     (pe_count[held.cluster_index]),
    .enable    (pe_enable_bits[held.cluster_index * PES_PER_CLUSTER +: PES_PER_CLUSTER]),
    .mask      (held.mappable_mask),
    .result    (search)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      ptr_valid <= '0;
    end else begin
      if (!finish && rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            held  <= req_word;
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (finish) begin
            rsp_valid         <= 1'b1;
            rsp_word.found    <= search.found;
            rsp_word.pe_index <= search.pe_index;
            if (search.found) begin
              ptr_valid[held_addr] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import crr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 16;
  localparam int PRINT_CAP = 60;

  typedef struct packed {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] value;
    crr_req_t             req;
    bit                   typed;
    crr_rsp_t             rsp;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  req_valid;
  logic                  req_stall;
  crr_req_t              req_word;
  logic                  rsp_valid;
  logic                  rsp_stall;
  crr_rsp_t              rsp_word;

  logic [CFG_DATA_W-1:0] pe_enabled;
  logic [COUNT_W-1:0]    pe_count [NUM_COUNT_REGS];
  logic [PTR_W-1:0]      rr_next [NUM_COUNT_REGS];

  crr_rsp_t picks_due[$];
  int       mismatches = 0;
  bit       send_quiet = 0;
  bit       recv_quiet = 0;

  clustered_round_robin_pe_picker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Scan the cluster from its pointer, wrapping at the element count, for an
  // element that is both enabled and allowed; advance the pointer on success.
  function automatic crr_rsp_t pick_pe(crr_req_t w);
    int       n;
    int       start;
    int       idx;
    int       cl;
    crr_rsp_t r;
    r = '0;
    cl = w.cluster_index;
    n = (pe_count[cl] > PES_PER_CLUSTER) ? PES_PER_CLUSTER : int'(pe_count[cl]);
    if (n == 0) return r;
    start = int'(rr_next[cl]) % n;
    for (int k = 0; k < n; k++) begin
      idx = (start + k) % n;
      if (pe_enabled[cl * PES_PER_CLUSTER + idx] && w.mappable_mask[idx]) begin
        rr_next[cl] = PTR_W'((idx + 1) % n);
        r.found = 1'b1;
        r.pe_index = PTR_W'(idx);
        return r;
      end
    end
    return r;
  endfunction

  function automatic plan_row_t pick_row(logic [CLUSTER_W-1:0] cl,
                                         logic [PES_PER_CLUSTER-1:0] mask, bit typed,
                                         logic found, logic [PTR_W-1:0] pe);
    plan_row_t row;
    row = '0;
    row.req.cluster_index = cl;
    row.req.mappable_mask = mask;
    row.typed = typed;
    row.rsp.found = found;
    row.rsp.pe_index = pe;
    return row;
  endfunction

  function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] v);
    plan_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.value = v;
    return row;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] enable_pattern();
    logic [CFG_DATA_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: v = '1;
      1: v = '0;
      2: v = v & {$urandom, $urandom};
      3: v = v | {$urandom, $urandom};
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] count_pattern();
    logic [CFG_DATA_W-1:0] v;
    v = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    case ($urandom_range(0, 7))
      0: v[COUNT_W-1:0] = '0;
      1: v[COUNT_W-1:0] = 5'd1;
      2: v[COUNT_W-1:0] = COUNT_RESET;
      3: v[COUNT_W-1:0] = '1;
      4: v[COUNT_W-1:0] = 5'd15;
      default: v[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 31));
    endcase
    return v;
  endfunction

  function automatic logic [PES_PER_CLUSTER-1:0] mask_pattern();
    logic [PES_PER_CLUSTER-1:0] m;
    m = PES_PER_CLUSTER'($urandom);
    case ($urandom_range(0, 5))
      0: m = '1;
      1: m = '0;
      2: m = PES_PER_CLUSTER'(1) << $urandom_range(0, PES_PER_CLUSTER - 1);
      3: m = m & PES_PER_CLUSTER'($urandom);
      default: ;
    endcase
    return m;
  endfunction

  task automatic report(string what, int got, int want);
    if (mismatches < PRINT_CAP)
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_PE_ENABLE: pe_enabled = v;
      REG_PE_COUNT0, REG_PE_COUNT1, REG_PE_COUNT2, REG_PE_COUNT3: begin
        pe_count[idx - REG_PE_COUNT0] = v[COUNT_W-1:0];
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_req(crr_req_t w, bit typed, crr_rsp_t typed_rsp);
    int       gap;
    crr_rsp_t due;
    cfg_we <= 1'b0;
    if ($urandom_range(0, 47) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word <= w;
    do @(posedge clk); while (req_stall !== 1'b0);
    due = pick_pe(w);
    picks_due.push_back(typed ? typed_rsp : due);
  endtask

  initial begin : receiver
    int       hold;
    crr_rsp_t want;
    hold = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        if (picks_due.size() == 0) begin
          report("unexpected word, pe_index", int'(rsp_word.pe_index), 0);
        end else begin
          want = picks_due.pop_front();
          if (rsp_word.found !== want.found)
            report("found", int'(rsp_word.found), int'(want.found));
          if (rsp_word.pe_index !== want.pe_index)
            report("pe_index", int'(rsp_word.pe_index), int'(want.pe_index));
        end
        if ($urandom_range(0, 47) == 0) recv_quiet = !recv_quiet;
        hold = recv_quiet ? 0 : $urandom_range(0, 6);
      end else if (hold > 0) begin
        hold--;
      end
      rsp_stall <= (hold != 0);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan[$];
    crr_req_t  w;
    int        n_items;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_valid = 1'b0;
    req_word = '0;
    pe_enabled = ENABLE_RESET;
    for (int c = 0; c < NUM_COUNT_REGS; c++) begin
      pe_count[c] = COUNT_RESET;
      rr_next[c] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    plan.push_back(pick_row(2'd0, 16'hFFFF, 1, 1'b1, 4'd0));
    plan.push_back(pick_row(2'd0, 16'hFFFF, 1, 1'b1, 4'd1));
    plan.push_back(pick_row(2'd0, 16'h0000, 1, 1'b0, 4'd0));
    plan.push_back(pick_row(2'd0, 16'h0001, 1, 1'b1, 4'd0));
    plan.push_back(pick_row(2'd1, 16'h8000, 1, 1'b1, 4'd15));
    plan.push_back(pick_row(2'd2, 16'hFFFF, 1, 1'b1, 4'd0));
    plan.push_back(pick_row(2'd3, 16'h8000, 1, 1'b1, 4'd15));
    plan.push_back(pick_row(2'd1, 16'h4000, 1, 1'b1, 4'd14));
    plan.push_back(write_row(REG_PE_COUNT1, 64'd5));
    plan.push_back(pick_row(2'd1, 16'hFFFF, 1, 1'b1, 4'd0));
    plan.push_back(write_row(REG_PE_COUNT2, 64'd0));
    plan.push_back(pick_row(2'd2, 16'hFFFF, 1, 1'b0, 4'd0));
    plan.push_back(write_row(REG_PE_COUNT3, 64'd31));
    plan.push_back(pick_row(2'd3, 16'h8000, 1, 1'b1, 4'd15));
    plan.push_back(write_row(REG_PE_ENABLE, 64'd0));
    plan.push_back(pick_row(2'd0, 16'hFFFF, 1, 1'b0, 4'd0));
    plan.push_back(write_row(REG_PE_ENABLE, 64'h8000_0000_0000_0001));
    plan.push_back(pick_row(2'd0, 16'hFFFF, 1, 1'b1, 4'd0));
    plan.push_back(pick_row(2'd3, 16'hFFFF, 1, 1'b1, 4'd15));
    plan.push_back(pick_row(2'd3, 16'h7FFF, 1, 1'b0, 4'd0));
    plan.push_back(write_row(CFG_IDX_W'(REG_PE_COUNT3 + 1), 64'd0));
    plan.push_back(write_row('1, 64'd0));
    plan.push_back(pick_row(2'd0, 16'h0001, 1, 1'b1, 4'd0));
    plan.push_back(write_row(REG_PE_COUNT0, 64'd1));
    plan.push_back(pick_row(2'd0, 16'hFFFF, 1, 1'b1, 4'd0));
    plan.push_back(write_row(REG_PE_COUNT3, 64'hFFFF_FFFF_FFFF_FFE0));
    plan.push_back(pick_row(2'd3, 16'hFFFF, 1, 1'b0, 4'd0));
    plan.push_back(write_row(REG_PE_COUNT3, 64'hFFFF_FFFF_FFFF_FFE3));
    plan.push_back(pick_row(2'd3, 16'hFFFF, 1, 1'b0, 4'd0));
    plan.push_back(write_row(REG_PE_ENABLE, ENABLE_RESET));
    plan.push_back(write_row(REG_PE_COUNT0, 64'(COUNT_RESET)));
    plan.push_back(write_row(REG_PE_COUNT1, 64'(COUNT_RESET)));
    plan.push_back(write_row(REG_PE_COUNT2, 64'(COUNT_RESET)));
    plan.push_back(write_row(REG_PE_COUNT3, 64'(COUNT_RESET)));
    plan.push_back(pick_row(2'd1, 16'hFFFF, 0, 1'b0, 4'd0));
    plan.push_back(pick_row(2'd2, 16'hA5A5, 0, 1'b0, 4'd0));

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain();
        set_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_req(plan[i].req, plan[i].typed, plan[i].rsp);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      if (ph == 0 || $urandom_range(0, 1) == 1) set_reg(REG_PE_ENABLE, enable_pattern());
      for (int c = 0; c < NUM_COUNT_REGS; c++) begin
        if (ph == 0 || $urandom_range(0, 1) == 1)
          set_reg(CFG_IDX_W'(REG_PE_COUNT0 + c), count_pattern());
      end
      if ($urandom_range(0, 3) == 0)
        set_reg(CFG_IDX_W'($urandom_range(REG_PE_COUNT3 + 1, (1 << CFG_IDX_W) - 1)),
                {$urandom, $urandom});
      n_items = $urandom_range(90, 130);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 99) == 0) drain();
        w.cluster_index = CLUSTER_W'($urandom_range(0, DEF_NUM_CLUSTERS - 1));
        w.mappable_mask = mask_pattern();
        send_req(w, 0, '0);
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
